/* rtl/ipfc_pkg.sv */
package ipfc_pkg;

    localparam int DIM_W       = 11;
    localparam int PIXEL_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 20;
    localparam int TOTAL_W     = 21;
    localparam int LEN_W       = 22;
    localparam int CFG_IDX_W   = 2;
    localparam int HDR_LEN     = 10;
    localparam int HDR_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0] DIM_MAX      = DIM_W'(1024);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(320);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(240);
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(320 * 240);
    // header plus crc bytes on top of the pixel bytes
    localparam logic [LEN_W-1:0] LEN_OVERHEAD = LEN_W'(HDR_LEN + 2);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [BYTE_W-1:0] MAGIC_0   = 8'h59;
    localparam logic [BYTE_W-1:0] MAGIC_1   = 8'h48;
    localparam logic [BYTE_W-1:0] MAGIC_2   = 8'h5A;
    localparam logic [BYTE_W-1:0] MAGIC_3   = 8'h53;
    localparam logic [BYTE_W-1:0] DEV_ADDR  = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_IMAGE = 8'h02;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_LEN - 1);

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               first;
        logic               last;
        logic [LEN_W-1:0]   len;
    } ipfc_entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } ipfc_qstat_t;

    typedef enum logic [2:0] {
        ST_START,
        ST_HDR,
        ST_PIX_LO,
        ST_PIX_HI,
        ST_CRC_HI,
        ST_CRC_LO
    } ipfc_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    function automatic logic [TOTAL_W-1:0] dim_product(input logic [DIM_W-1:0] a,
                                                       input logic [DIM_W-1:0] b);
        logic [2*DIM_W-1:0] p;
        p = {{DIM_W{1'b0}}, a} * {{DIM_W{1'b0}}, b};
        return p[TOTAL_W-1:0];
    endfunction

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                               input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                                   input logic [LEN_W-1:0] len);
        logic [31:0]       len32;
        logic [BYTE_W-1:0] b;
        len32 = 32'(len);
        case (idx)
            4'd0:    b = MAGIC_0;
            4'd1:    b = MAGIC_1;
            4'd2:    b = MAGIC_2;
            4'd3:    b = MAGIC_3;
            4'd4:    b = DEV_ADDR;
            4'd5:    b = len32[31:24];
            4'd6:    b = len32[23:16];
            4'd7:    b = len32[15:8];
            4'd8:    b = len32[7:0];
            default: b = CMD_IMAGE;
        endcase
        return b;
    endfunction

endpackage

/* rtl/ipfc_front.sv */
module ipfc_front
    import ipfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIXEL_W-1:0]   pixel,
    input  ipfc_qstat_t          q_stat,
    output logic                 push,
    output ipfc_entry_t          push_entry
);

    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               last;

    // pixel count of the frame is recomputed on each width or height register write
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        total_next  = total_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    width_next = cfg_data;
                    total_next = dim_product(clamp_dim(cfg_data), clamp_dim(height_reg));
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_next = cfg_data;
                    total_next  = dim_product(clamp_dim(width_reg), clamp_dim(cfg_data));
                end
                default:
                begin
                    total_next = total_reg;
                end
            endcase
        end
    end

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;
    assign last     = (TOTAL_W'(count_reg) + TOTAL_W'(1)) >= total_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = last ? '0 : count_reg + COUNT_W'(1);
        end
    end

    always_comb
    begin
        push_entry.pixel = pixel;
        push_entry.first = (count_reg == '0);
        push_entry.last  = last;
        push_entry.len   = {total_reg, 1'b0} + LEN_OVERHEAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            total_reg  <= TOTAL_RESET;
            count_reg  <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            total_reg  <= total_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/ipfc_queue.sv */
module ipfc_queue
    import ipfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ipfc_entry_t push_entry,
    input  logic        pop,
    output ipfc_entry_t head,
    output ipfc_qstat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipfc_entry_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push not counted");

endmodule

/* rtl/ipfc_back.sv */
module ipfc_back
    import ipfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ipfc_entry_t        head,
    input  ipfc_qstat_t        q_stat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  out_byte,
    output logic               frame_end
);

    ipfc_state_t          state_reg, state_next;
    logic [HDR_IDX_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]          crc_reg, crc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic                 frame_end_reg;
    logic                 advance;
    logic [BYTE_W-1:0]    byte_sel;
    logic                 end_sel;
    logic                 feed_crc;

    // one byte leaves per cycle whenever the queue holds a request and the output slot is free
    assign advance = q_stat.valid && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        if (advance)
        begin
            case (state_reg)
                ST_START:
                begin
                    if (head.first)
                    begin
                        state_next   = ST_HDR;
                        hdr_cnt_next = HDR_IDX_W'(1);
                    end
                    else
                    begin
                        state_next = ST_PIX_HI;
                    end
                end
                ST_HDR:
                begin
                    if (hdr_cnt_reg == HDR_LAST)
                    begin
                        state_next   = ST_PIX_LO;
                        hdr_cnt_next = '0;
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + HDR_IDX_W'(1);
                    end
                end
                ST_PIX_LO: state_next = ST_PIX_HI;
                ST_PIX_HI: state_next = head.last ? ST_CRC_HI : ST_START;
                ST_CRC_HI: state_next = ST_CRC_LO;
                ST_CRC_LO: state_next = ST_START;
                default:   state_next = ST_START;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        byte_sel = head.pixel[7:0];
        end_sel  = 1'b0;
        feed_crc = 1'b1;
        pop      = 1'b0;
        case (state_reg)
            ST_START:
            begin
                byte_sel = head.first ? hdr_byte('0, head.len) : head.pixel[7:0];
            end
            ST_HDR:
            begin
                byte_sel = hdr_byte(hdr_cnt_reg, head.len);
            end
            ST_PIX_LO:
            begin
                byte_sel = head.pixel[7:0];
            end
            ST_PIX_HI:
            begin
                byte_sel = head.pixel[15:8];
                pop      = advance && !head.last;
            end
            ST_CRC_HI:
            begin
                byte_sel = crc_reg[15:8];
                feed_crc = 1'b0;
            end
            ST_CRC_LO:
            begin
                byte_sel = crc_reg[7:0];
                end_sel  = 1'b1;
                feed_crc = 1'b0;
                pop      = advance;
            end
            default:
            begin
                feed_crc = 1'b0;
            end
        endcase

        crc_next = crc_reg;
        if (advance)
        begin
            if (state_reg == ST_CRC_LO)
            begin
                crc_next = CRC_INIT;
            end
            else if (feed_crc)
            begin
                crc_next = crc16_feed(crc_reg, byte_sel);
            end
        end
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg  <= byte_sel;
            frame_end_reg <= end_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            hdr_cnt_reg   <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_mid_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_START |-> q_stat.valid)
        else $error("request left the queue before all its bytes were sent");

    a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HDR |-> hdr_cnt_reg != '0 && hdr_cnt_reg <= HDR_LAST)
        else $error("header index out of range");

    a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg == ST_CRC_LO |=> out_valid_reg && frame_end_reg
            && crc_reg == CRC_INIT)
        else $error("frame end not marked or crc not restarted");

    a_end_only_crc: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg != ST_CRC_LO |=> !frame_end_reg)
        else $error("frame end on a non-final byte");

endmodule

/* rtl/image_packet_framer_crc16.sv */
// image packet framer with crc-16
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is frame
//   width, index 1 is frame height; other indexes are dropped; always ready
// - input channel (in_valid/in_stall, pixel): one rgb565 pixel per request
// - output channel (out_valid/out_stall, out_byte, frame_end): one packet byte
//   per request; frame_end marks the last crc byte of a packet
// - the first pixel of a frame adds a 10-byte header, every pixel gives two
//   bytes low first, the last pixel adds the two crc bytes high first
// - throughput: one byte per cycle out of the back end while the queue holds a
//   request and the output is not stalled
// - path: an accepted pixel is written into the queue, and the back end then
//   registers each byte of it in the output register that drives out_byte
// - a 4-deep queue separates front end (classify, count) and back end (byte
//   sequencer, crc); in_stall rises only while the queue is full
// - stall on the output holds the byte register; the queue keeps filling
// - reset: size 320x240, crc 0xffff, pixel count zero, queue empty
module image_packet_framer_crc16
    import ipfc_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIXEL_W-1:0]   pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 frame_end
);

    ipfc_entry_t push_entry;
    ipfc_entry_t head;
    ipfc_qstat_t q_stat;
    logic        push;
    logic        pop;

    // register writes take effect in the next cycle
    assign cfg_ready = 1'b1;

    // front end: size registers, pixel counter, first/last tagging
    ipfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue between the two halves
    ipfc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    // back end: byte sequencer, running crc, output register
    ipfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ipfc_pkg::*;

    // indexes the block has no register behind; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    localparam int RANDOM_PIXELS  = 500;  // random part stops once this many pixels went in
    localparam int CALM_TAIL      = 60;   // last pixels of the run go without any idling
    localparam int RUN_CAP        = 40;   // longest burst of pixels per size setting
    localparam int WATCHDOG_LIMIT = 4000; // cycles without a single handshake
    localparam int DRAIN_CYCLES   = 20;   // extra cycles at the end to catch stray bytes

    // ------------------------------------------------------------------
    // packet predictor and byte scoreboard
    // ------------------------------------------------------------------
    class packet_scoreboard;
        logic [DIM_W-1:0]   width_reg;
        logic [DIM_W-1:0]   height_reg;
        logic [15:0]        crc_run;
        logic [COUNT_W-1:0] taken;
        logic [BYTE_W-1:0]  byte_q[$];
        logic               end_q[$];
        int                 mismatches;
        int                 bytes_seen;
        int                 packets_closed;
        int                 pixels_seen;
        int                 reg_writes;

        function new();
            width_reg      = WIDTH_RESET;
            height_reg     = HEIGHT_RESET;
            crc_run        = CRC_INIT;
            taken          = '0;
            mismatches     = 0;
            bytes_seen     = 0;
            packets_closed = 0;
            pixels_seen    = 0;
            reg_writes     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            reg_writes++;
            if (idx == CFG_FRAME_WIDTH)
            begin
                width_reg = data;
            end
            else if (idx == CFG_FRAME_HEIGHT)
            begin
                height_reg = data;
            end
        endfunction

        // zero acts as one, anything past 1024 acts as 1024
        function int limit_dim(logic [DIM_W-1:0] v);
            int r;
            r = int'(v);
            if (r == 0)
            begin
                r = 1;
            end
            else if (r > 1024)
            begin
                r = 1024;
            end
            return r;
        endfunction

        function int frame_total();
            return limit_dim(width_reg) * limit_dim(height_reg);
        endfunction

        // pixels still missing before the current packet closes
        function int frame_left();
            return frame_total() - int'(taken);
        endfunction

        function int pending();
            return byte_q.size();
        endfunction

        // queue one packet byte, optionally folding it into the crc bit by bit
        function void push_byte(logic [BYTE_W-1:0] b, logic last, bit fold);
            logic fb;
            byte_q.push_back(b);
            end_q.push_back(last);
            if (fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    fb      = crc_run[0] ^ b[i];
                    crc_run = crc_run >> 1;
                    if (fb)
                    begin
                        crc_run = crc_run ^ CRC_POLY;
                    end
                end
            end
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] px);
            logic [31:0] total;
            logic [31:0] len;
            logic [15:0] crc_snap;
            total = 32'(frame_total());
            pixels_seen++;
            if (taken == '0)
            begin
                len = 32'(HDR_LEN + 2) + 32'd2 * total;
                push_byte(MAGIC_0, 1'b0, 1'b1);
                push_byte(MAGIC_1, 1'b0, 1'b1);
                push_byte(MAGIC_2, 1'b0, 1'b1);
                push_byte(MAGIC_3, 1'b0, 1'b1);
                push_byte(DEV_ADDR, 1'b0, 1'b1);
                push_byte(len[31:24], 1'b0, 1'b1);
                push_byte(len[23:16], 1'b0, 1'b1);
                push_byte(len[15:8], 1'b0, 1'b1);
                push_byte(len[7:0], 1'b0, 1'b1);
                push_byte(CMD_IMAGE, 1'b0, 1'b1);
            end
            push_byte(px[7:0], 1'b0, 1'b1);
            push_byte(px[15:8], 1'b0, 1'b1);
            if (32'(taken) + 32'd1 >= total)
            begin
                crc_snap = crc_run;
                push_byte(crc_snap[15:8], 1'b0, 1'b0);
                push_byte(crc_snap[7:0], 1'b1, 1'b0);
                crc_run = CRC_INIT;
                taken   = '0;
                packets_closed++;
            end
            else
            begin
                taken = taken + 1'b1;
            end
        endfunction

        function void check_byte(logic [BYTE_W-1:0] b, logic last);
            logic [BYTE_W-1:0] exp_b;
            logic              exp_last;
            if (byte_q.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: byte %02h frame_end %0b with nothing outstanding",
                             $realtime, b, last);
                end
                mismatches++;
                return;
            end
            exp_b    = byte_q.pop_front();
            exp_last = end_q.pop_front();
            bytes_seen++;
            if (b !== exp_b || last !== exp_last)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: byte #%0d out_byte %02h/%02h frame_end %0b/%0b (exp/got)",
                             $realtime, bytes_seen, exp_b, b, exp_last, last);
                end
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIXEL_W-1:0]   pixel;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    out_byte;
    logic                 frame_end;

    packet_scoreboard sb;

    // idling knobs, changed per size setting by the stimulus thread
    int idle_pct;
    int stall_pct;
    bit calm;
    int stall_left;
    int stuck_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    image_packet_framer_crc16 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

    // ------------------------------------------------------------------
    // output side: check every accepted byte, then decide the next stall
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        // handshake values read here are the ones from before the edge
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_byte(out_byte, frame_end);
        end
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (!calm && rst_n && $urandom_range(0, 99) < stall_pct)
        begin
            // start a stall burst, this one included; stall_left counts the rest
            out_stall  <= 1'b1;
            stall_left = $urandom_range(1, 14) - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles = stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, giving up", $realtime,
                         stuck_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------

    // hold off until every predicted byte has left the block
    task automatic wait_idle();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // register writes only go in while the block is empty; valid stays up across
    // back-to-back writes and drops after the last one
    task automatic program_regs(input logic [CFG_IDX_W-1:0] idx_q[$],
                                input logic [DIM_W-1:0] data_q[$]);
        wait_idle();
        for (int i = 0; i < idx_q.size(); i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_q[i];
            cfg_data  <= data_q[i];
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            sb.set_reg(idx_q[i], data_q[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // one pixel request per entry; an idle burst may come before any of them,
    // otherwise valid stays high straight into the next request
    task automatic send_pixels(input logic [PIXEL_W-1:0] px_q[$]);
        for (int i = 0; i < px_q.size(); i++)
        begin
            if (!calm && $urandom_range(0, 99) < idle_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            in_valid <= 1'b1;
            pixel    <= px_q[i];
            do
            begin
                @(posedge clk);
            end
            while (in_stall);
            sb.note_pixel(px_q[i]);
        end
        in_valid <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        logic [PIXEL_W-1:0] px;
        case ($urandom_range(0, 9))
            0:       px = '0;
            1:       px = '1;
            default: px = PIXEL_W'($urandom_range(0, 65535));
        endcase
        return px;
    endfunction

    // pick a frame size; mostly tiny so many packets close, now and then one
    // side clamped or past the limit so the long length field shows up
    task automatic random_setup();
        logic [CFG_IDX_W-1:0] idx_q[$];
        logic [DIM_W-1:0]     data_q[$];
        logic [DIM_W-1:0]     w;
        logic [DIM_W-1:0]     h;
        case ($urandom_range(0, 11))
            0:
            begin
                w = DIM_W'($urandom_range(1025, 2047));
                h = DIM_W'($urandom_range(0, 1));
            end
            1:
            begin
                w = DIM_W'($urandom_range(0, 1));
                h = DIM_W'($urandom_range(1025, 2047));
            end
            2:
            begin
                w = '0;
                h = DIM_W'($urandom_range(0, 4));
            end
            3:
            begin
                w = DIM_W'(1024);
                h = DIM_W'($urandom_range(0, 2));
            end
            default:
            begin
                w = DIM_W'($urandom_range(1, 8));
                h = DIM_W'($urandom_range(1, 6));
            end
        endcase
        // a write to a missing register, with junk data, should change nothing
        if ($urandom_range(0, 3) == 0)
        begin
            idx_q.push_back($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3);
            data_q.push_back(DIM_W'($urandom_range(0, 2047)));
        end
        // sometimes only one register is touched and the other one carries over
        case ($urandom_range(0, 5))
            0:
            begin
                idx_q.push_back(CFG_FRAME_WIDTH);
                data_q.push_back(w);
            end
            1:
            begin
                idx_q.push_back(CFG_FRAME_HEIGHT);
                data_q.push_back(h);
            end
            2:
            begin
                idx_q.push_back(CFG_FRAME_HEIGHT);
                data_q.push_back(h);
                idx_q.push_back(CFG_FRAME_WIDTH);
                data_q.push_back(w);
            end
            default:
            begin
                idx_q.push_back(CFG_FRAME_WIDTH);
                data_q.push_back(w);
                idx_q.push_back(CFG_FRAME_HEIGHT);
                data_q.push_back(h);
            end
        endcase
        program_regs(idx_q, data_q);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int                 random_sent;
        int                 n;
        int                 left;
        logic [PIXEL_W-1:0] px_q[$];

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel        = '0;
        out_stall    = 1'b0;
        idle_pct     = 20;
        stall_pct    = 20;
        calm         = 1'b0;
        stall_left   = 0;
        stuck_cycles = 0;
        random_sent  = 0;
        sb           = new();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset size 320x240, partial frame with extreme pixels
        send_pixels('{16'h0000, 16'hFFFF});
        // shrink to 1x1 mid-frame: the very next pixel closes the packet
        program_regs('{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT}, '{11'd1, 11'd1});
        send_pixels('{16'h1234, 16'hAAAA, 16'h5555});
        // zero sizes act as one
        program_regs('{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT}, '{11'd0, 11'd0});
        send_pixels('{16'h00FF, 16'hFF00});
        // oversize width clamps to 1024
        program_regs('{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT}, '{11'd2047, 11'd1});
        send_pixels('{16'h8001, 16'h7FFE, 16'h0F0F});
        // grow to the largest frame mid-packet, then shrink below the count
        program_regs('{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT}, '{11'd1024, 11'd1024});
        send_pixels('{16'hF0F0, 16'h3C3C});
        program_regs('{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT}, '{11'd1, 11'd2});
        send_pixels('{16'hC3C3});
        // header of a 1024x1024 packet carries the widest length field
        program_regs('{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT}, '{11'd1024, 11'd1024});
        send_pixels('{16'h0001, 16'h8000});
        program_regs('{CFG_FRAME_HEIGHT, CFG_FRAME_WIDTH}, '{11'd0, 11'd2});
        send_pixels('{16'h4321});
        // spare indexes are dropped, then a full 3x2 packet
        program_regs('{CFG_SPARE_2, CFG_SPARE_3, CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT},
                     '{11'h7FF, 11'h555, 11'd3, 11'd2});
        send_pixels('{16'h0000, 16'hFFFF, 16'h1111, 16'hEEEE, 16'h2468, 16'hDB97});

        // random part: each round waits for the block to drain, writes a new
        // size and sends a burst of pixels, usually exactly to the end of a packet
        while (random_sent < RANDOM_PIXELS)
        begin
            if (random_sent >= RANDOM_PIXELS - CALM_TAIL)
            begin
                calm = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        idle_pct  = 0;
                        stall_pct = 0;
                    end
                    1:
                    begin
                        idle_pct  = 40;
                        stall_pct = 40;
                    end
                    default:
                    begin
                        idle_pct  = $urandom_range(0, 30);
                        stall_pct = $urandom_range(0, 30);
                    end
                endcase
            end
            random_setup();
            left = sb.frame_left();
            if (left < 1)
            begin
                left = 1;
            end
            case ($urandom_range(0, 4))
                0:       n = $urandom_range(1, 3);
                1:       n = left + sb.frame_total();
                default: n = left;
            endcase
            if (n > RUN_CAP)
            begin
                n = RUN_CAP;
            end
            px_q.delete();
            repeat (n) px_q.push_back(rand_pixel());
            send_pixels(px_q);
            random_sent += n;
        end

        // let everything drain, then watch a little longer for extra bytes
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0d predicted bytes never came out", sb.pending());
        end
        $display("run covered %0d pixels in %0d closed packets, %0d bytes compared",
                 sb.pixels_seen, sb.packets_closed, sb.bytes_seen);
        $display("%0d register writes: sizes 1x1 to 1024x1024, clamped and spare writes",
                 sb.reg_writes);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ipfc_pkg.sv
rtl/ipfc_front.sv
rtl/ipfc_queue.sv
rtl/ipfc_back.sv
rtl/image_packet_framer_crc16.sv
sim/tb_top.sv
